/* rtl/rgb_sequence_command_parser_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef RGB_SEQUENCE_COMMAND_PARSER_MACROS_SVH
`define RGB_SEQUENCE_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rsp_pkg.sv */
package rsp_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_INITIAL = 3'd0,
        PH_PROFILE = 3'd1,
        PH_DELAY   = 3'd2,
        PH_COLOR   = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    // Result codes.
    typedef enum logic [1:0] {
        RES_NEXT   = 2'd0,
        RES_ACCEPT = 2'd1,
        RES_ERROR  = 2'd2
    } res_t;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_CAPS  = 2'd1,
        REQ_PRINT = 2'd2,
        REQ_SET   = 2'd3
    } req_t;

    localparam int DELAY_W   = 27;
    localparam int COLOR_W   = 24;
    localparam int DIGIT_W   = 4;
    localparam int SEQLEN_W  = 5;
    localparam int INDEX_W   = 4;

    localparam logic [DIGIT_W-1:0] COLOR_DIGITS = 4'd6;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // One result item.
    typedef struct packed {
        res_t                  result_code;
        req_t                  request_kind;
        logic [SEQLEN_W-1:0]   sequence_length;
        logic                  entry_valid;
        logic [INDEX_W-1:0]    entry_index;
        logic [DELAY_W-1:0]    entry_delay;
        logic [7:0]            entry_red;
        logic [7:0]            entry_green;
        logic [7:0]            entry_blue;
    } result_t;

    // Flow control between the input register and the result register.
    typedef struct packed {
        logic advance;
        logic out_free;
    } flow_t;

endpackage

/* rtl/rsp_in_stage.sv */
module rsp_in_stage (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  rsp_pkg::flow_t flow,
    output logic        full,
    output logic [7:0]  char_out
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;

    // The register takes a new character when empty or when its item moves on.
    assign s_ready  = !valid_reg || flow.advance;
    assign full     = valid_reg;
    assign char_out = char_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (flow.advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded on every input transfer.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_in;
        end
    end

endmodule

/* rtl/rsp_parser.sv */
`include "rgb_sequence_command_parser_macros.svh"

module rsp_parser #(
    parameter int MAX_ENTRIES      = 16,
    parameter int MAX_DELAY_DIGITS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       char_in,
    output rsp_pkg::result_t res
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [rsp_pkg::DIGIT_W-1:0] DELAY_DIGITS_MAX =
        rsp_pkg::DIGIT_W'(MAX_DELAY_DIGITS);

    rsp_pkg::phase_t                  phase_reg, phase_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [rsp_pkg::DELAY_W-1:0]      delay_reg, delay_next;
    logic [rsp_pkg::COLOR_W-1:0]      color_reg, color_next;
    logic [rsp_pkg::DIGIT_W-1:0]      digits_reg, digits_next;
    rsp_pkg::req_t                    request_reg, request_next;

    logic                             is_crlf;
    logic                             is_dec;
    logic [4:0]                       nib;
    logic [rsp_pkg::DELAY_W-1:0]      delay_acc;
    logic [rsp_pkg::COLOR_W-1:0]      color_acc;
    logic [rsp_pkg::DIGIT_W-1:0]      digits_inc;

    // Nibble value of a hex character, 16 when it is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = 5'(c[3:0]) + 5'd9;
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    // Character classes and the accumulator updates.
    assign is_crlf    = (char_in == rsp_pkg::CHAR_CR) || (char_in == rsp_pkg::CHAR_LF);
    assign is_dec     = (char_in >= 8'h30) && (char_in <= 8'h39);
    assign nib        = hex_value(char_in);
    assign delay_acc  = (delay_reg << 3) + (delay_reg << 1)
                        + rsp_pkg::DELAY_W'(char_in[3:0]);
    assign color_acc  = {color_reg[rsp_pkg::COLOR_W-5:0], nib[3:0]};
    assign digits_inc = digits_reg + 1'b1;

    // Next state and the result for the character in the input register.
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        delay_next   = delay_reg;
        color_next   = color_reg;
        digits_next  = digits_reg;
        request_next = request_reg;
        res          = '0;
        res.result_code = rsp_pkg::RES_NEXT;

        if (char_in != rsp_pkg::CHAR_SPACE) begin
            unique case (phase_reg)
                rsp_pkg::PH_INITIAL: begin
                    if (char_in == rsp_pkg::CHAR_S) begin
                        count_next = '0;
                        phase_next = rsp_pkg::PH_PROFILE;
                    end else if (char_in == rsp_pkg::CHAR_C) begin
                        request_next = rsp_pkg::REQ_CAPS;
                        phase_next   = rsp_pkg::PH_DONE;
                    end else begin
                        res.result_code = rsp_pkg::RES_ERROR;
                    end
                end
                rsp_pkg::PH_PROFILE: begin
                    if (char_in == rsp_pkg::CHAR_L || char_in == rsp_pkg::CHAR_T) begin
                        delay_next  = '0;
                        digits_next = '0;
                        phase_next  = rsp_pkg::PH_DELAY;
                    end else if (is_crlf) begin
                        request_next = (count_reg == '0) ? rsp_pkg::REQ_PRINT
                                                         : rsp_pkg::REQ_SET;
                        phase_next      = rsp_pkg::PH_INITIAL;
                        res.result_code = rsp_pkg::RES_ACCEPT;
                    end else begin
                        phase_next      = rsp_pkg::PH_INITIAL;
                        res.result_code = rsp_pkg::RES_ERROR;
                    end
                end
                rsp_pkg::PH_DELAY: begin
                    if (is_dec) begin
                        if (digits_reg >= DELAY_DIGITS_MAX) begin
                            phase_next      = rsp_pkg::PH_INITIAL;
                            res.result_code = rsp_pkg::RES_ERROR;
                        end else begin
                            delay_next  = delay_acc;
                            digits_next = digits_inc;
                        end
                    end else if (char_in == rsp_pkg::CHAR_HASH) begin
                        color_next  = '0;
                        digits_next = '0;
                        phase_next  = rsp_pkg::PH_COLOR;
                    end
                end
                rsp_pkg::PH_COLOR: begin
                    if (!nib[4]) begin
                        color_next  = color_acc;
                        digits_next = digits_inc;
                        if (digits_inc >= rsp_pkg::COLOR_DIGITS) begin
                            if (count_reg >= CNT_MAX) begin
                                phase_next      = rsp_pkg::PH_INITIAL;
                                res.result_code = rsp_pkg::RES_ERROR;
                            end else begin
                                res.entry_valid = 1'b1;
                                res.entry_index = rsp_pkg::INDEX_W'(count_reg);
                                res.entry_delay = delay_reg;
                                res.entry_red   = color_acc[23:16];
                                res.entry_green = color_acc[15:8];
                                res.entry_blue  = color_acc[7:0];
                                count_next      = count_reg + 1'b1;
                                phase_next      = rsp_pkg::PH_PROFILE;
                            end
                        end
                    end else begin
                        phase_next      = rsp_pkg::PH_INITIAL;
                        res.result_code = rsp_pkg::RES_ERROR;
                    end
                end
                rsp_pkg::PH_DONE: begin
                    phase_next      = rsp_pkg::PH_INITIAL;
                    res.result_code = is_crlf ? rsp_pkg::RES_ACCEPT : rsp_pkg::RES_ERROR;
                end
                default: begin
                    phase_next      = rsp_pkg::PH_INITIAL;
                    res.result_code = is_crlf ? rsp_pkg::RES_ACCEPT : rsp_pkg::RES_ERROR;
                end
            endcase
        end

        res.request_kind    = request_next;
        res.sequence_length = rsp_pkg::SEQLEN_W'(count_next);
    end

    // Parser state advances once per character that moves to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= rsp_pkg::PH_INITIAL;
            count_reg   <= '0;
            delay_reg   <= '0;
            color_reg   <= '0;
            digits_reg  <= '0;
            request_reg <= rsp_pkg::REQ_NONE;
        end else if (step) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            delay_reg   <= delay_next;
            color_reg   <= color_next;
            digits_reg  <= digits_next;
            request_reg <= request_next;
        end
    end

    `RSP_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_MAX,
        "Entry count exceeds the sequence limit.")
    `RSP_ASSERT_NOW(a_delay_digits, aclk, aresetn, phase_reg == rsp_pkg::PH_DELAY,
        digits_reg <= DELAY_DIGITS_MAX, "Delay digit count exceeds its limit.")
    `RSP_ASSERT_NEXT(a_hold_no_step, aclk, aresetn, !step,
        $stable(phase_reg) && $stable(count_reg), "Parser state moved without a step.")

endmodule

/* rtl/rsp_out_stage.sv */
module rsp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_full,
    input  rsp_pkg::result_t res_in,
    input  logic             m_ready,
    output logic             m_valid,
    output rsp_pkg::result_t res_out,
    output rsp_pkg::flow_t   flow
);

    logic             valid_reg;
    logic             valid_next;
    rsp_pkg::result_t res_reg;

    // A result moves in when the register is empty or is being drained.
    assign flow.out_free = !valid_reg || m_ready;
    assign flow.advance  = in_full && flow.out_free;
    assign m_valid       = valid_reg;
    assign res_out       = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (flow.advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (flow.advance) begin
            res_reg <= res_in;
        end
    end

endmodule

/* rtl/rgb_sequence_command_parser.sv */
// Channel  | Direction | Handshake         | Payload
// s_       | in        | s_valid / s_ready | s_char_in[7:0]
// m_       | out       | m_valid / m_ready | result code, request kind, length, entry fields
//
// One character per clock is sustained while m_ready is high; a character passes
// through an input register and then the result register, with the parse logic between them.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// parser to its initial phase with no request and no entries.
// While m_ready is low the result holds; the input register then fills and
// s_ready drops until the result transfer completes.

`include "rgb_sequence_command_parser_macros.svh"

module rgb_sequence_command_parser #(
    parameter int MAX_ENTRIES      = 16,
    parameter int MAX_DELAY_DIGITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_code,
    output logic [1:0]  m_request_kind,
    output logic [4:0]  m_sequence_length,
    output logic        m_entry_valid,
    output logic [3:0]  m_entry_index,
    output logic [26:0] m_entry_delay,
    output logic [7:0]  m_entry_red,
    output logic [7:0]  m_entry_green,
    output logic [7:0]  m_entry_blue
);

    rsp_pkg::flow_t   flow;
    rsp_pkg::result_t res_comb;
    rsp_pkg::result_t res_out;
    logic             in_full;
    logic [7:0]       char_q;

    rsp_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .flow      (flow),
        .full      (in_full),
        .char_out  (char_q)
    );

    rsp_parser #(
        .MAX_ENTRIES      (MAX_ENTRIES),
        .MAX_DELAY_DIGITS (MAX_DELAY_DIGITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (flow.advance),
        .char_in (char_q),
        .res     (res_comb)
    );

    rsp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_full (in_full),
        .res_in  (res_comb),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .res_out (res_out),
        .flow    (flow)
    );

    // Result fields to the output ports.
    assign m_result_code     = res_out.result_code;
    assign m_request_kind    = res_out.request_kind;
    assign m_sequence_length = res_out.sequence_length;
    assign m_entry_valid     = res_out.entry_valid;
    assign m_entry_index     = res_out.entry_index;
    assign m_entry_delay     = res_out.entry_delay;
    assign m_entry_red       = res_out.entry_red;
    assign m_entry_green     = res_out.entry_green;
    assign m_entry_blue      = res_out.entry_blue;

    `RSP_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, in_full && m_valid && !m_ready,
        !s_ready, "Input taken while the pipeline is stalled.")
    `RSP_ASSERT_NOW(a_entry_code, aclk, aresetn, m_valid && m_entry_valid,
        m_result_code == rsp_pkg::RES_NEXT, "Completed entry carries a non-pending code.")
    `RSP_ASSERT_NOW(a_entry_zero, aclk, aresetn, m_valid && !m_entry_valid,
        m_entry_delay == '0 && m_entry_index == '0 && m_entry_red == '0,
        "Entry fields are not cleared without an entry.")

endmodule
